// ----- hw/rtl/tgq_pkg.sv -----
// ----------------------------------------------------------------------------
// tgq_pkg: shared types and constants
// Item layouts, qualifier state, mode and event codes, CSR indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tgq_pkg;

   localparam int CoordW     = 16;
   localparam int TimeW      = 16;
   localparam int ThreshW    = 15;
   localparam int KindW      = 2;
   localparam int CsrAddrW   = 1;
   localparam int CsrDataW   = 16;

   localparam logic [CoordW-1:0]  NO_TOUCH_LIMIT = 16'hff00;
   localparam logic [CoordW-1:0]  NO_POINT       = 16'hffff;

   localparam logic [TimeW-1:0]   DEBOUNCE_RESET  = 16'd50;
   localparam logic [ThreshW-1:0] THRESHOLD_RESET = 15'd4;

   // request kinds
   localparam logic REQ_PEN_IRQ = 1'b0;
   localparam logic REQ_POLL    = 1'b1;

   // event kinds
   localparam logic [KindW-1:0] EV_NONE = 2'd0;
   localparam logic [KindW-1:0] EV_DOWN = 2'd1;
   localparam logic [KindW-1:0] EV_MOVE = 2'd2;
   localparam logic [KindW-1:0] EV_UP   = 2'd3;

   // CSR indexes
   localparam logic [CsrAddrW-1:0] CSR_DEBOUNCE  = 1'b0;
   localparam logic [CsrAddrW-1:0] CSR_THRESHOLD = 1'b1;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'b001,
      MODE_TOUCHING = 3'b010,
      MODE_RELEASED = 3'b100
   } mode_type;

   typedef struct packed {
      logic              req_type;
      logic [CoordW-1:0] sample_x;
      logic [CoordW-1:0] sample_y;
      logic [TimeW-1:0]  now_ms;
   } req_item_type;

   typedef struct packed {
      logic [KindW-1:0]  event_kind;
      logic [CoordW-1:0] event_x;
      logic [CoordW-1:0] event_y;
   } rsp_item_type;

   typedef struct packed {
      mode_type          mode;
      logic [CoordW-1:0] prev_x;
      logic [CoordW-1:0] prev_y;
      logic [TimeW-1:0]  release_stamp;
   } state_type;

   typedef struct packed {
      logic [TimeW-1:0]   debounce_time;
      logic [ThreshW-1:0] move_gap;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tgq_if.sv -----
// ----------------------------------------------------------------------------
// tgq_if: channel interfaces
// Valid/ready channels for request items and event items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgq_req_if import tgq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CoordW-1:0] sample_x;
   logic [CoordW-1:0] sample_y;
   logic [TimeW-1:0]  now_ms;

   modport source (output valid, req_type, sample_x, sample_y, now_ms, input ready);
   modport sink   (input valid, req_type, sample_x, sample_y, now_ms, output ready);
endinterface

interface tgq_rsp_if import tgq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KindW-1:0]  event_kind;
   logic [CoordW-1:0] event_x;
   logic [CoordW-1:0] event_y;

   modport source (output valid, event_kind, event_x, event_y, input ready);
   modport sink   (input valid, event_kind, event_x, event_y, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tgq_eval.sv -----
// ----------------------------------------------------------------------------
// tgq_eval: qualifier next-state and event logic
// Combinational: one item plus current state gives one event and next state.
// ----------------------------------------------------------------------------
`default_nettype none

module tgq_eval import tgq_pkg::*; (
   input  req_item_type item,
   input  state_type    cur,
   input  cfg_type      cfg,
   output rsp_item_type res,
   output state_type    nxt
);

   logic                no_touch;
   logic [TimeW-1:0]    elapsed;
   logic signed [CoordW:0] dx;
   logic signed [CoordW:0] dy;
   logic [CoordW:0]     adx;
   logic [CoordW:0]     ady;
   logic                big_move;
   logic                first_pt;
   logic                same_pt;
   logic                active;

   assign no_touch = (item.sample_x > NO_TOUCH_LIMIT) || (item.sample_y > NO_TOUCH_LIMIT);
   assign elapsed  = item.now_ms - cur.release_stamp;

   // 17-bit signed distance, no wrap
   assign dx  = signed'({item.sample_x[CoordW-1], item.sample_x})
              - signed'({cur.prev_x[CoordW-1], cur.prev_x});
   assign dy  = signed'({item.sample_y[CoordW-1], item.sample_y})
              - signed'({cur.prev_y[CoordW-1], cur.prev_y});
   assign adx = dx[CoordW] ? unsigned'(-dx) : unsigned'(dx);
   assign ady = dy[CoordW] ? unsigned'(-dy) : unsigned'(dy);
   assign big_move = (adx > {2'b00, cfg.move_gap})
                  && (ady > {2'b00, cfg.move_gap});

   assign first_pt = (cur.prev_x == NO_POINT) && (cur.prev_y == NO_POINT);
   assign same_pt  = (cur.prev_x == item.sample_x) && (cur.prev_y == item.sample_y);

   // touching path: touching mode, or touch seen again while released
   assign active = (cur.mode == MODE_TOUCHING) || ((cur.mode == MODE_RELEASED) && !no_touch);

   always_comb begin
      res = '{event_kind: EV_NONE, event_x: '0, event_y: '0};
      nxt = cur;
      priority if (item.req_type == REQ_PEN_IRQ) begin
         if (cur.mode != MODE_TOUCHING && cur.mode != MODE_RELEASED) begin
            nxt.mode = MODE_TOUCHING;
         end
      end else if (active) begin
         if (no_touch) begin
            nxt.mode          = MODE_RELEASED;
            nxt.release_stamp = item.now_ms;
         end else begin
            nxt.mode   = MODE_TOUCHING;
            nxt.prev_x = item.sample_x;
            nxt.prev_y = item.sample_y;
            if (first_pt) begin
               res = '{event_kind: EV_DOWN, event_x: item.sample_x, event_y: item.sample_y};
            end else if (!same_pt && big_move) begin
               res = '{event_kind: EV_MOVE, event_x: item.sample_x, event_y: item.sample_y};
            end
         end
      end else if (cur.mode == MODE_RELEASED) begin
         // still no touch: report up once debounce has run out
         if (elapsed > cfg.debounce_time) begin
            res = '{event_kind: EV_UP, event_x: cur.prev_x, event_y: cur.prev_y};
            nxt.mode   = MODE_IDLE;
            nxt.prev_x = NO_POINT;
            nxt.prev_y = NO_POINT;
         end
      end else begin
         // poll while idle: no event, state unchanged
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/touch_gesture_qualifier.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_qualifier: touch-panel event qualifier
// Turns pen interrupts and sample polls into down, move and up events.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per pen-down interrupt (req_type 0) or periodic
//     poll (req_type 1, with sample_x/sample_y/now_ms).
//   rsp channel: exactly one event item per request item, in order;
//     event_kind 0 (none) carries zero coordinates.
//   csr port: index 0 debounce_time (ms), index 1 move distance threshold;
//     write only while no items are in flight.
//   Path: an accepted item goes through the input register, then the event
//     register, which drives rsp.valid. Throughput: one item per cycle while
//     rsp.ready is high; the qualifier state is updated as an item moves
//     into the event register, so the next item sees the updated state.
//   Stall: when rsp.ready is low the event register holds and the input
//     register fills; req.ready falls only when both stages are occupied.
//   Reset: synchronous, active high; both stages empty, mode idle, no
//     previous point, release stamp zero, CSRs at 50 ms and 4.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_qualifier import tgq_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   tgq_req_if.sink                  req,
   tgq_rsp_if.source                rsp,
   input  wire logic                csr_we,
   input  wire logic [CsrAddrW-1:0] csr_addr,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   // configuration registers
   cfg_type      cfg_ff;

   // input stage
   logic         s1_valid_ff;
   req_item_type s1_item_ff;

   // event stage
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   // qualifier state
   state_type    state_ff;
   state_type    state_in;
   rsp_item_type rsp_item_in;

   logic         adv_out;   // event register free or being drained
   logic         take_in;   // request item accepted this edge
   logic         fire;      // input stage moves to event stage

   assign adv_out   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || adv_out;
   assign take_in   = req.valid && req.ready;
   assign fire      = s1_valid_ff && adv_out;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= DEBOUNCE_RESET;
         cfg_ff.move_gap      <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEBOUNCE:  cfg_ff.debounce_time <= csr_wdata[TimeW-1:0];
            CSR_THRESHOLD: cfg_ff.move_gap      <= csr_wdata[ThreshW-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         s1_item_ff <= '{req_type: req.req_type, sample_x: req.sample_x,
                         sample_y: req.sample_y, now_ms: req.now_ms};
      end
   end

   tgq_eval u_eval (
      .item (s1_item_ff),
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .res  (rsp_item_in),
      .nxt  (state_in)
   );

   // state advances with each item entering the event register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_IDLE, prev_x: NO_POINT, prev_y: NO_POINT,
                       release_stamp: '0};
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // event register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_kind = rsp_item_ff.event_kind;
   assign rsp.event_x    = rsp_item_ff.event_x;
   assign rsp.event_y    = rsp_item_ff.event_y;

endmodule

`default_nettype wire

// ----- hw/rtl/tgq_checker.sv -----
// ----------------------------------------------------------------------------
// tgq_checker: port-level assertions for the qualifier
// Bound to the top level; watches the channel ports only.
// ----------------------------------------------------------------------------
`default_nettype none

module tgq_checker import tgq_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KindW-1:0]  event_kind,
   input wire logic [CoordW-1:0] event_x,
   input wire logic [CoordW-1:0] event_y
);

   // stalled event holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_kind)
         && $stable(event_x) && $stable(event_y))
      else $error("stalled event changed");

   // an empty (none) event carries zero coordinates
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_kind == EV_NONE) |-> (event_x == '0) && (event_y == '0))
      else $error("empty event with nonzero coordinates");

   // down and move report a touched point
   a_touch_pt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((event_kind == EV_DOWN) || (event_kind == EV_MOVE))
         |-> (event_x <= NO_TOUCH_LIMIT) && (event_y <= NO_TOUCH_LIMIT))
      else $error("down/move with no-touch coordinates");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("event valid after reset");

endmodule

bind touch_gesture_qualifier tgq_checker u_tgq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .event_kind (rsp.event_kind),
   .event_x    (rsp.event_x),
   .event_y    (rsp.event_y)
);

`default_nettype wire

// ----- verif/touch_gesture_qualifier_checker.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_qualifier_checker: event predictor and scoreboard
// Watches the request, event and CSR ports, predicts one event per accepted
// request item and compares each delivered event item against it in order.
// ----------------------------------------------------------------------------
module touch_gesture_qualifier_checker import tgq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   tgq_req_if                  req,
   tgq_rsp_if                  rsp,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  mismatches,
   output int                  pending,
   output int                  down_seen,
   output int                  move_seen,
   output int                  up_seen,
   output int                  quiet_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   state_type    track;
   cfg_type      cfg_shadow;
   rsp_item_type expected_events[$];
   req_item_type seen_req;
   rsp_item_type seen_rsp;
   rsp_item_type want;

   // distance on one axis, coordinates taken as signed 16-bit, no wrap
   function automatic int axis_gap(input logic [CoordW-1:0] a, input logic [CoordW-1:0] b);
      int ia;
      int ib;
      ia = $signed(a);
      ib = $signed(b);
      return (ia > ib) ? ia - ib : ib - ia;
   endfunction

   // advances the tracked qualifier state by one item, returns its event
   function automatic rsp_item_type qualify_sample(input req_item_type it);
      rsp_item_type ev;
      logic         no_touch;
      logic [TimeW-1:0] elapsed;
      ev = '0;
      ev.event_kind = EV_NONE;
      no_touch = (it.sample_x > NO_TOUCH_LIMIT) || (it.sample_y > NO_TOUCH_LIMIT);
      if (it.req_type == REQ_PEN_IRQ) begin
         if (track.mode != MODE_TOUCHING && track.mode != MODE_RELEASED)
            track.mode = MODE_TOUCHING;
         return ev;
      end
      if (track.mode != MODE_TOUCHING && track.mode != MODE_RELEASED)
         return ev;
      if (track.mode == MODE_RELEASED) begin
         if (no_touch) begin
            elapsed = it.now_ms - track.release_stamp;
            if (elapsed > cfg_shadow.debounce_time) begin
               ev.event_kind = EV_UP;
               ev.event_x    = track.prev_x;
               ev.event_y    = track.prev_y;
               track.mode    = MODE_IDLE;
               track.prev_x  = NO_POINT;
               track.prev_y  = NO_POINT;
            end
            return ev;
         end
         track.mode = MODE_TOUCHING;
      end
      if (no_touch) begin
         track.mode          = MODE_RELEASED;
         track.release_stamp = it.now_ms;
         return ev;
      end
      if (track.prev_x == NO_POINT && track.prev_y == NO_POINT) begin
         ev.event_kind = EV_DOWN;
         ev.event_x    = it.sample_x;
         ev.event_y    = it.sample_y;
      end else if (track.prev_x != it.sample_x || track.prev_y != it.sample_y) begin
         if (axis_gap(it.sample_x, track.prev_x) > int'(cfg_shadow.move_gap) &&
             axis_gap(it.sample_y, track.prev_y) > int'(cfg_shadow.move_gap)) begin
            ev.event_kind = EV_MOVE;
            ev.event_x    = it.sample_x;
            ev.event_y    = it.sample_y;
         end
      end
      track.prev_x = it.sample_x;
      track.prev_y = it.sample_y;
      return ev;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         track.mode               = MODE_IDLE;
         track.prev_x             = NO_POINT;
         track.prev_y             = NO_POINT;
         track.release_stamp      = '0;
         cfg_shadow.debounce_time = DEBOUNCE_RESET;
         cfg_shadow.move_gap      = THRESHOLD_RESET;
         expected_events.delete();
         mismatches = 0;
         down_seen  = 0;
         move_seen  = 0;
         up_seen    = 0;
         quiet_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DEBOUNCE:  cfg_shadow.debounce_time = csr_wdata;
               CSR_THRESHOLD: cfg_shadow.move_gap      = csr_wdata[ThreshW-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            seen_req = {req.req_type, req.sample_x, req.sample_y, req.now_ms};
            expected_events.push_back(qualify_sample(seen_req));
         end
         if (rsp.valid && rsp.ready) begin
            seen_rsp = {rsp.event_kind, rsp.event_x, rsp.event_y};
            if (expected_events.size() == 0) begin
               $error("event item with nothing expected: kind %0d x %h y %h",
                      seen_rsp.event_kind, seen_rsp.event_x, seen_rsp.event_y);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (seen_rsp.event_kind !== want.event_kind) begin
                  $error("event_kind expected %0d actual %0d",
                         want.event_kind, seen_rsp.event_kind);
                  mismatches++;
               end
               if (seen_rsp.event_x !== want.event_x) begin
                  $error("event_x expected %h actual %h", want.event_x, seen_rsp.event_x);
                  mismatches++;
               end
               if (seen_rsp.event_y !== want.event_y) begin
                  $error("event_y expected %h actual %h", want.event_y, seen_rsp.event_y);
                  mismatches++;
               end
               case (want.event_kind)
                  EV_DOWN: down_seen++;
                  EV_MOVE: move_seen++;
                  EV_UP:   up_seen++;
                  default: quiet_seen++;
               endcase
            end
         end
      end
      pending = expected_events.size();
   end

endmodule

// ----- verif/touch_gesture_qualifier_tb.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_qualifier_tb: testbench top for the touch event qualifier
// Drives pen interrupts and sample polls with random idling on both channels,
// steps through several CSR settings and leaves checking to the checker.
// ----------------------------------------------------------------------------
module touch_gesture_qualifier_tb import tgq_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 250;
   localparam int PHASES       = 6;
   localparam int HOLD_CYCLES  = 60;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CsrAddrW-1:0] csr_addr;
   logic [CsrDataW-1:0] csr_wdata;

   int mismatches;
   int pending;
   int down_seen;
   int move_seen;
   int up_seen;
   int quiet_seen;

   // stimulus bookkeeping
   int               cycle_count;
   int               items_sent;
   int               cur_dbn;
   int               cur_thr;
   logic [TimeW-1:0] clock_ms;
   bit               gaps_on;
   bit               rsp_idle_on;
   int               hold_requested;
   int               hold_served;
   int               hold_left;
   int               stall_left;

   tgq_req_if req_ch ();
   tgq_rsp_if rsp_ch ();

   touch_gesture_qualifier uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   touch_gesture_qualifier_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending),
      .down_seen  (down_seen),
      .move_seen  (move_seen),
      .up_seen    (up_seen),
      .quiet_seen (quiet_seen)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("touch_gesture_qualifier_tb NOT OK");
         $finish;
      end
   end

   // event receiver: random stall bursts of random length, plus a long
   // hold-off on request so the two internal stages fill and req stalls
   initial begin
      rsp_ch.ready = 1'b0;
      hold_served  = 0;
      hold_left    = 0;
      stall_left   = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requested) begin
            hold_served = hold_requested;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // offer one item and wait for its handshake; valid stays high on return
   // unless a random gap is taken, so back-to-back items follow without idling
   task automatic send_item(input logic rt, input logic [CoordW-1:0] x,
                            input logic [CoordW-1:0] y, input logic [TimeW-1:0] t);
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= rt;
      req_ch.sample_x <= x;
      req_ch.sample_y <= y;
      req_ch.now_ms   <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // stop offering and wait until every predicted event has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // both registers, back to back; bit 15 of the threshold write is junk
   task automatic configure(input int dbn, input int thr);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_DEBOUNCE;
      csr_wdata <= 16'(dbn);
      @(posedge clock);
      csr_addr  <= CSR_THRESHOLD;
      csr_wdata <= {1'($urandom_range(0, 1)), 15'(thr)};
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_dbn = dbn;
      cur_thr = thr;
   endtask

   // a lifted sample: one or both axes above the no-touch limit
   task automatic pick_no_touch(output logic [CoordW-1:0] x, output logic [CoordW-1:0] y);
      int sel;
      sel = $urandom_range(0, 2);
      x = 16'($urandom_range(0, 16'hffff));
      y = 16'($urandom_range(0, 16'hffff));
      if (sel != 1) x = 16'($urandom_range(16'hff01, 16'hffff));
      if (sel != 0) y = 16'($urandom_range(16'hff01, 16'hffff));
   endtask

   function automatic logic [CoordW-1:0] clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > int'(NO_TOUCH_LIMIT)) return NO_TOUCH_LIMIT;
      return 16'(v);
   endfunction

   // one touch: interrupt, a run of polls near threshold, then a lift that
   // is held past the debounce window; some are cut short or skip the irq
   task automatic run_gesture();
      logic [CoordW-1:0] px;
      logic [CoordW-1:0] py;
      logic [CoordW-1:0] nx;
      logic [CoordW-1:0] ny;
      logic [TimeW-1:0]  stamp;
      int                span;
      int                dx;
      int                dy;
      if ($urandom_range(0, 9) != 0)
         send_item(REQ_PEN_IRQ, 16'($urandom), 16'($urandom), 16'($urandom));
      px = 16'($urandom_range(0, 16'hff00));
      py = 16'($urandom_range(0, 16'hff00));
      repeat ($urandom_range(1, 8)) begin
         span = cur_thr + 3;
         if ($urandom_range(0, 5) == 0) span = 16'hff00;
         dx = int'($urandom_range(0, 2 * span)) - span;
         dy = int'($urandom_range(0, 2 * span)) - span;
         if ($urandom_range(0, 7) == 0) begin
            dx = 0;
            dy = 0;
         end
         px = clamp_coord(int'(px) + dx);
         py = clamp_coord(int'(py) + dy);
         clock_ms = clock_ms + 16'($urandom_range(1, 30));
         send_item(REQ_POLL, px, py, clock_ms);
      end
      // finger stays down: next gesture's irq is ignored
      if ($urandom_range(0, 5) == 0) return;
      stamp = clock_ms;
      pick_no_touch(nx, ny);
      send_item(REQ_POLL, nx, ny, stamp);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 5) == 0) begin
            // bounce: contact returns inside the window, then lifts again
            clock_ms = clock_ms + 16'd1;
            send_item(REQ_POLL, px, py, clock_ms);
            clock_ms = clock_ms + 16'd1;
            stamp    = clock_ms;
            pick_no_touch(nx, ny);
            send_item(REQ_POLL, nx, ny, stamp);
         end else begin
            pick_no_touch(nx, ny);
            send_item(REQ_POLL, nx, ny, 16'(int'(stamp) + int'($urandom_range(0, cur_dbn))));
         end
      end
      // exactly at the window edge nothing happens, one past it releases
      pick_no_touch(nx, ny);
      send_item(REQ_POLL, nx, ny, 16'(int'(stamp) + cur_dbn));
      pick_no_touch(nx, ny);
      clock_ms = 16'(int'(stamp) + cur_dbn + 1 + int'($urandom_range(0, 3)));
      send_item(REQ_POLL, nx, ny, clock_ms);
   endtask

   // directed opening under reset CSR values (debounce 50, threshold 4)
   task automatic directed_items();
      send_item(REQ_POLL, 16'h0000, 16'h0000, 16'd0);        // poll while idle
      send_item(REQ_PEN_IRQ, 16'hffff, 16'hffff, 16'hffff);  // wake, fields ignored
      send_item(REQ_PEN_IRQ, 16'h1234, 16'h5678, 16'h0000);  // irq while touching
      send_item(REQ_POLL, 16'h0000, 16'h0000, 16'd10);       // first contact: down
      send_item(REQ_POLL, 16'h0000, 16'h0000, 16'd20);       // same point
      send_item(REQ_POLL, 16'h0004, 16'h0004, 16'd30);       // equal to threshold
      send_item(REQ_POLL, 16'h0009, 16'h0064, 16'd40);       // move
      send_item(REQ_POLL, 16'h0009, 16'h00c8, 16'd50);       // one axis only
      send_item(REQ_POLL, 16'h7fff, 16'h8000, 16'd60);       // sign crossing
      send_item(REQ_POLL, 16'h8000, 16'h7fff, 16'd70);       // widest distance
      send_item(REQ_POLL, 16'hff00, 16'hff00, 16'd80);       // limit still a touch
      send_item(REQ_POLL, 16'hff01, 16'h0000, 16'hfff0);     // lift, stamp near wrap
      send_item(REQ_PEN_IRQ, 16'h0000, 16'h0000, 16'h0000);  // irq while released
      send_item(REQ_POLL, 16'h0000, 16'hffff, 16'h0022);     // elapsed 50, held
      send_item(REQ_POLL, 16'hff00, 16'hff00, 16'h0023);     // re-touch same point
      send_item(REQ_POLL, 16'hffff, 16'hffff, 16'h0100);     // lift again
      send_item(REQ_POLL, 16'hffff, 16'hff01, 16'h0133);     // elapsed 51: up
      send_item(REQ_POLL, 16'h0010, 16'h0010, 16'h0140);     // poll while idle
      send_item(REQ_PEN_IRQ, 16'h0000, 16'h0000, 16'h0000);
      send_item(REQ_POLL, 16'hffff, 16'h0000, 16'h0150);     // lift with no point
      send_item(REQ_POLL, 16'hffff, 16'hffff, 16'h0200);     // up with no point
      send_item(REQ_PEN_IRQ, 16'h0000, 16'h0000, 16'h0000);
      send_item(REQ_POLL, 16'hff00, 16'h0000, 16'h0210);     // down at x limit
      send_item(REQ_POLL, 16'h0000, 16'hff00, 16'h0220);     // move across panel
   endtask

   initial begin
      int  phase;
      int  quota;
      int  dbn;
      int  thr;
      bit  last;
      bit  paused_once;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_POLL;
      req_ch.sample_x = '0;
      req_ch.sample_y = '0;
      req_ch.now_ms   = '0;
      csr_we          = 1'b0;
      csr_addr        = CSR_DEBOUNCE;
      csr_wdata       = '0;
      items_sent      = 0;
      cur_dbn         = int'(DEBOUNCE_RESET);
      cur_thr         = int'(THRESHOLD_RESET);
      clock_ms        = '0;
      gaps_on         = 1'b1;
      rsp_idle_on     = 1'b1;
      hold_requested  = 0;
      paused_once     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         // extremes first, then random and mid-range settings
         case (phase)
            0: begin dbn = 0;     thr = 0;     end
            1: begin dbn = 65535; thr = 32767; end
            2: begin dbn = $urandom_range(0, 65535); thr = $urandom_range(0, 32767); end
            3: begin dbn = int'(DEBOUNCE_RESET); thr = int'(THRESHOLD_RESET); end
            4: begin dbn = $urandom_range(1, 300); thr = $urandom_range(0, 40); end
            default: begin dbn = $urandom_range(0, 100); thr = $urandom_range(0, 12); end
         endcase
         configure(dbn, thr);
         last  = (phase == PHASES - 1);
         quota = items_sent + PHASE_ITEMS;
         // long receiver hold-off while the sender keeps offering
         if (phase == 3) hold_requested++;
         while (items_sent < quota) begin
            // idling comes and goes per stretch; none in the final phase
            gaps_on     = !last && ($urandom_range(0, 3) != 0);
            rsp_idle_on = !last && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 4))
                  send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                            16'($urandom));
            end else begin
               run_gesture();
            end
            // sender pause mid-phase until the pipeline is empty
            if (phase == 2 && !paused_once && items_sent > quota - PHASE_ITEMS / 2) begin
               drain();
               paused_once = 1'b1;
            end
         end
         drain();
      end

      repeat (8) @(posedge clock);
      $display("ran %0d items over %0d CSR settings, receiver hold-off and sender pause",
               items_sent, PHASES + 1);
      $display("events: %0d down, %0d move, %0d up, %0d none",
               down_seen, move_seen, up_seen, quiet_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("touch_gesture_qualifier_tb OK");
      end else begin
         $display("touch_gesture_qualifier_tb NOT OK");
      end
      $finish;
   end

endmodule
